// File: rtl/slf_pkg.sv
// ----------------------------------------------------------------------------
// slf_pkg: session lifecycle controller package
// Shared widths, state and event codes, and the guard result struct.
// ----------------------------------------------------------------------------
package slf_pkg;

  localparam int OpW  = 4;
  localparam int StW  = 4;
  localparam int GenW = 64;

  typedef enum logic [StW-1:0] {
    ST_IDLE         = 4'd0,
    ST_LISTENING    = 4'd1,
    ST_CONNECTING   = 4'd2,
    ST_AWAITING     = 4'd3,
    ST_NEGOTIATING  = 4'd4,
    ST_CONNECTED    = 4'd5,
    ST_STREAMING    = 4'd6,
    ST_RECONNECTING = 4'd7,
    ST_STOPPING     = 4'd8,
    ST_TIMEDOUT     = 4'd9
  } sess_state_t;

  typedef enum logic [OpW-1:0] {
    OP_SET_ROLE  = 4'd0,
    OP_LISTEN    = 4'd1,
    OP_CONNECT   = 4'd2,
    OP_AWAIT     = 4'd3,
    OP_APPROVE   = 4'd4,
    OP_REJECT    = 4'd5,
    OP_CONNECTED = 4'd6,
    OP_STREAM    = 4'd7,
    OP_UNSTREAM  = 4'd8,
    OP_RECONNECT = 4'd9,
    OP_RESTORE   = 4'd10,
    OP_STOP      = 4'd11,
    OP_TIMEOUT   = 4'd12,
    OP_FINISH    = 4'd13,
    OP_QUERY     = 4'd14
  } op_t;

  localparam logic ROLE_CONTROLLER = 1'b0;
  localparam logic ROLE_CONTROLLED = 1'b1;

  // One registered event
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           new_role;
    logic           keep;
  } event_t;

  // Guard decision and the state it leaves behind
  typedef struct packed {
    logic        accepted;
    sess_state_t state;
    logic        role;
    logic        flag;
    logic        gen_inc;
  } guard_res_t;

  function automatic logic session_active(sess_state_t s);
    return (s != ST_IDLE) && (s != ST_LISTENING) &&
           (s != ST_STOPPING) && (s != ST_TIMEDOUT);
  endfunction

endpackage

// File: rtl/slf_if.sv
// ----------------------------------------------------------------------------
// slf_if: session lifecycle channels
// Valid/ready channels for events in and results out.
// ----------------------------------------------------------------------------
interface slf_in_if import slf_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] operation;
  logic           new_role;
  logic           keep_listening;

  modport source (output valid, operation, new_role, keep_listening, input ready);
  modport sink   (input valid, operation, new_role, keep_listening, output ready);
endinterface

interface slf_out_if import slf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            accepted;
  logic [StW-1:0]  session_state;
  logic            current_role;
  logic [GenW-1:0] session_generation;
  logic            can_enter_remote_desktop;
  logic            can_start_controlled_streaming;
  logic            can_send_input;
  logic            can_receive_input;
  logic            can_sync_clipboard;
  logic            in_negotiation;
  logic            has_active_session;

  modport source (
    output valid, accepted, session_state, current_role, session_generation,
           can_enter_remote_desktop, can_start_controlled_streaming,
           can_send_input, can_receive_input, can_sync_clipboard,
           in_negotiation, has_active_session,
    input  ready
  );
  modport sink (
    input  valid, accepted, session_state, current_role, session_generation,
           can_enter_remote_desktop, can_start_controlled_streaming,
           can_send_input, can_receive_input, can_sync_clipboard,
           in_negotiation, has_active_session,
    output ready
  );
endinterface

// File: rtl/slf_guard.sv
// ----------------------------------------------------------------------------
// slf_guard: event guard and transition logic
// Decides whether an event is accepted and what state it leaves behind.
// ----------------------------------------------------------------------------
module slf_guard import slf_pkg::*; (
  input  event_t      ev,
  input  sess_state_t cur_state,
  input  logic        cur_role,
  input  logic        cur_flag,
  output guard_res_t  res
);

  always_comb begin
    res.accepted = 1'b0;
    res.state    = cur_state;
    res.role     = cur_role;
    res.flag     = cur_flag;
    res.gen_inc  = 1'b0;
    case (op_t'(ev.op))
      OP_SET_ROLE: begin
        if (cur_state == ST_IDLE) begin
          res.role     = ev.new_role;
          res.accepted = 1'b1;
        end
      end
      OP_LISTEN: begin
        if (cur_state == ST_IDLE) begin
          res.role     = ROLE_CONTROLLED;
          res.state    = ST_LISTENING;
          res.flag     = 1'b0;
          res.gen_inc  = 1'b1;
          res.accepted = 1'b1;
        end
      end
      OP_CONNECT: begin
        if (cur_state == ST_IDLE) begin
          res.role     = ROLE_CONTROLLER;
          res.state    = ST_CONNECTING;
          res.flag     = 1'b0;
          res.gen_inc  = 1'b1;
          res.accepted = 1'b1;
        end
      end
      OP_AWAIT: begin
        // only the listening side opens a new generation here
        if (cur_state == ST_LISTENING) begin
          res.state    = ST_AWAITING;
          res.gen_inc  = 1'b1;
          res.accepted = 1'b1;
        end else if (cur_state == ST_CONNECTING) begin
          res.state    = ST_AWAITING;
          res.accepted = 1'b1;
        end
      end
      OP_APPROVE: begin
        if (cur_state == ST_AWAITING) begin
          res.state    = ST_NEGOTIATING;
          res.accepted = 1'b1;
        end
      end
      OP_REJECT: begin
        if (cur_state == ST_AWAITING) begin
          res.state    = (cur_role == ROLE_CONTROLLED) ? ST_LISTENING : ST_IDLE;
          res.flag     = 1'b0;
          res.accepted = 1'b1;
        end
      end
      OP_CONNECTED: begin
        if (cur_state == ST_NEGOTIATING || cur_state == ST_CONNECTED) begin
          res.state    = ST_CONNECTED;
          res.flag     = 1'b0;
          res.accepted = 1'b1;
        end
      end
      OP_STREAM: begin
        if (cur_state == ST_CONNECTED) begin
          res.state    = ST_STREAMING;
          res.flag     = 1'b0;
          res.accepted = 1'b1;
        end
      end
      OP_UNSTREAM: begin
        if (cur_state == ST_STREAMING) begin
          res.state    = ST_CONNECTED;
          res.flag     = 1'b0;
          res.accepted = 1'b1;
        end
      end
      OP_RECONNECT: begin
        if (session_active(cur_state) && cur_state != ST_RECONNECTING) begin
          res.flag     = (cur_state == ST_STREAMING);
          res.state    = ST_RECONNECTING;
          res.accepted = 1'b1;
        end
      end
      OP_RESTORE: begin
        if (cur_state == ST_RECONNECTING) begin
          res.state    = cur_flag ? ST_STREAMING : ST_CONNECTED;
          res.flag     = 1'b0;
          res.accepted = 1'b1;
        end
      end
      OP_STOP: begin
        if (cur_state != ST_IDLE && cur_state != ST_STOPPING &&
            cur_state != ST_TIMEDOUT) begin
          res.state    = ST_STOPPING;
          res.accepted = 1'b1;
        end
      end
      OP_TIMEOUT: begin
        if (cur_state == ST_STOPPING) begin
          res.state    = ST_TIMEDOUT;
          res.accepted = 1'b1;
        end
      end
      OP_FINISH: begin
        res.state    = (ev.keep && cur_role == ROLE_CONTROLLED) ? ST_LISTENING : ST_IDLE;
        res.flag     = 1'b0;
        res.accepted = 1'b1;
      end
      OP_QUERY: begin
        res.accepted = 1'b1;
      end
      default: begin
        // unused code: refused, nothing changes
        res.accepted = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/session_lifecycle_fsm_top.sv
// ----------------------------------------------------------------------------
// session_lifecycle_fsm_top: session lifecycle controller
// Ten-state session FSM with role, reconnect flag and generation counter.
// ----------------------------------------------------------------------------
// Pipeline: an input transfer loads the event register; the guard result
//   moves into the result register when that is free or being drained.
// Throughput: one event per cycle while the sink keeps ready high; the
//   guard and the 64-bit generation add sit between the two registers.
// Reset (rst_n low, synchronous): state idle, role controller, reconnect
//   flag and generation cleared, both pipeline registers empty.
// ----------------------------------------------------------------------------
module session_lifecycle_fsm_top import slf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  slf_in_if.sink    in_ch,
  slf_out_if.source out_ch
);

  // Event register: one event waiting for its turn at the guard
  logic        ev_valid_r;
  event_t      ev_r;

  // Session state
  sess_state_t state_r;
  logic        role_r;
  logic        flag_r;
  logic [GenW-1:0] gen_r;
  logic [GenW-1:0] gen_nxt;

  // Result register
  logic        out_valid_r;
  logic        out_acc_r;
  sess_state_t out_state_r;
  logic        out_role_r;
  logic [GenW-1:0] out_gen_r;

  guard_res_t  res;
  logic        advance;

  // The event moves into the result register when that register is free
  // or being drained this cycle; the event register refills behind it.
  assign advance     = ev_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !ev_valid_r || advance;

  slf_guard u_guard (
    .ev        (ev_r),
    .cur_state (state_r),
    .cur_role  (role_r),
    .cur_flag  (flag_r),
    .res       (res)
  );

  // wrapping generation counter
  assign gen_nxt = res.gen_inc ? gen_r + GenW'(1) : gen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_IDLE;
      role_r      <= ROLE_CONTROLLER;
      flag_r      <= 1'b0;
      gen_r       <= '0;
    end else begin
      if (in_ch.ready) begin
        ev_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= res.state;
        role_r      <= res.role;
        flag_r      <= res.flag;
        gen_r       <= gen_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ev_r.op       <= in_ch.operation;
      ev_r.new_role <= in_ch.new_role;
      ev_r.keep     <= in_ch.keep_listening;
    end
    if (advance) begin
      out_acc_r   <= res.accepted;
      out_state_r <= res.state;
      out_role_r  <= res.role;
      out_gen_r   <= gen_nxt;
    end
  end

  // Permission flags decode from the registered state and role
  assign out_ch.valid              = out_valid_r;
  assign out_ch.accepted           = out_acc_r;
  assign out_ch.session_state      = out_state_r;
  assign out_ch.current_role       = out_role_r;
  assign out_ch.session_generation = out_gen_r;
  assign out_ch.can_enter_remote_desktop =
    (out_role_r == ROLE_CONTROLLER) && (out_state_r == ST_CONNECTED);
  assign out_ch.can_start_controlled_streaming =
    (out_role_r == ROLE_CONTROLLED) && (out_state_r == ST_CONNECTED);
  assign out_ch.can_send_input =
    (out_role_r == ROLE_CONTROLLER) && (out_state_r == ST_STREAMING);
  assign out_ch.can_receive_input =
    (out_role_r == ROLE_CONTROLLED) && (out_state_r == ST_STREAMING);
  assign out_ch.can_sync_clipboard = (out_state_r == ST_STREAMING);
  assign out_ch.in_negotiation =
    (out_state_r == ST_CONNECTING) || (out_state_r == ST_AWAITING) ||
    (out_state_r == ST_NEGOTIATING);
  assign out_ch.has_active_session = session_active(out_state_r);

`ifndef SYNTH
  // a refused event leaves the session untouched
  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !res.accepted |=> $stable(state_r) && $stable(role_r) &&
                                 $stable(gen_r))
    else $error("refused event changed session state");

  // session state only moves when an event goes through the guard
  a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r) && $stable(gen_r) && $stable(flag_r))
    else $error("session state moved without an event");

  // the reported result matches the session state it left behind
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_state_r == state_r && out_gen_r == gen_r &&
                out_role_r == role_r)
    else $error("result out of step with session state");

  // reconnect flag is only held from reconnecting on through teardown;
  // stop and timeout keep it, finish and restore clear it
  a_flag_only_reconnecting: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r |-> (state_r == ST_RECONNECTING) || (state_r == ST_STOPPING) ||
               (state_r == ST_TIMEDOUT))
    else $error("reconnect flag set outside reconnecting");
`endif

endmodule

// File: test/session_lifecycle_fsm_top_tb.sv
// ----------------------------------------------------------------------------
// session_lifecycle_fsm_top_tb: session lifecycle controller testbench
// A short directed walk through every event and guard, then a few hundred
// random events, mostly legal for the current state so that deep states are
// reached. A local predictor tracks state, role, reconnect flag and
// generation; every result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module session_lifecycle_fsm_top_tb;
  import slf_pkg::*;

  // Code 15 has no event behind it; the block must refuse it
  localparam logic [OpW-1:0] OP_UNUSED = 4'd15;

  localparam int RandEvents = 550;
  localparam int HoldCycles = 60;   // long sink hold-off, fills the pipe
  localparam int DrainLimit = 2000; // cycles allowed for the last results

  // One stimulus row. When pinned is set, accepted/state/generation come
  // from the row itself instead of the predictor.
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic            new_role;
    logic            keep;
    logic            pinned;
    logic            acc;
    sess_state_t     st;
    logic [GenW-1:0] gen;
  } steer_row_t;

  // Everything one result transfer carries
  typedef struct packed {
    logic            accepted;
    logic [StW-1:0]  state;
    logic            role;
    logic [GenW-1:0] gen;
    logic            desk;
    logic            ctl_stream;
    logic            send_in;
    logic            recv_in;
    logic            clip;
    logic            negot;
    logic            active;
  } sess_view_t;

  logic clk = 1'b0;
  logic rst_n;

  slf_in_if  in_if ();
  slf_out_if out_if ();

  session_lifecycle_fsm_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #1 clk = ~clk;

  // Predictor state: mirrors the controller after every accepted transfer
  sess_state_t     pr_state;
  logic            pr_role;
  logic            pr_resume;   // streaming was active before reconnect
  logic [GenW-1:0] pr_gen;

  sess_view_t pending_views[$];   // expected results, oldest first
  int errors = 0;
  int n_seen = 0;

  bit calm     = 1'b0;   // both sides stop idling while set
  bit hold_req = 1'b0;   // asks the sink process for a long hold-off

  // --------------------------------------------------------------------------
  // Directed walk. Pinned rows: reset state, the unused code, refusals in
  // idle, the first generation step, a refused repeat reconnect, and finish.
  // --------------------------------------------------------------------------
  steer_row_t steer_tbl [0:24] = '{
    '{OP_QUERY,     1'b0, 1'b0, 1'b1, 1'b1, ST_IDLE,         64'd0},
    '{OP_UNUSED,    1'b1, 1'b1, 1'b1, 1'b0, ST_IDLE,         64'd0},
    '{OP_SET_ROLE,  1'b1, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_SET_ROLE,  1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_AWAIT,     1'b0, 1'b0, 1'b1, 1'b0, ST_IDLE,         64'd0},
    '{OP_STOP,      1'b0, 1'b0, 1'b1, 1'b0, ST_IDLE,         64'd0},
    '{OP_LISTEN,    1'b0, 1'b0, 1'b1, 1'b1, ST_LISTENING,    64'd1},
    '{OP_AWAIT,     1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_REJECT,    1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_AWAIT,     1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_APPROVE,   1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_CONNECTED, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_CONNECTED, 1'b1, 1'b1, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_STREAM,    1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_RECONNECT, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_RECONNECT, 1'b0, 1'b0, 1'b1, 1'b0, ST_RECONNECTING, 64'd3},
    '{OP_RESTORE,   1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_UNSTREAM,  1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_STOP,      1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_TIMEOUT,   1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_FINISH,    1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_FINISH,    1'b1, 1'b0, 1'b1, 1'b1, ST_IDLE,         64'd3},
    '{OP_CONNECT,   1'b1, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_AWAIT,     1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0},
    '{OP_REJECT,    1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE,         64'd0}
  };

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // A session is live unless idle, listening, stopping or timed out
  function automatic logic live_state(sess_state_t s);
    return !(s inside {ST_IDLE, ST_LISTENING, ST_STOPPING, ST_TIMEDOUT});
  endfunction

  // Applies one event to the mirrored state and returns what the block
  // must report for it. Refused events leave everything untouched.
  function automatic sess_view_t advance_session(logic [OpW-1:0] op, logic nr,
                                                 logic keep);
    sess_state_t s;
    logic        ok;
    sess_view_t  v;
    s  = pr_state;
    ok = 1'b0;
    case (op)
      OP_SET_ROLE: if (s == ST_IDLE) begin
        pr_role = nr;
        ok      = 1'b1;
      end
      OP_LISTEN: if (s == ST_IDLE) begin
        pr_role   = ROLE_CONTROLLED;
        pr_state  = ST_LISTENING;
        pr_resume = 1'b0;
        pr_gen    = pr_gen + 1'b1;
        ok        = 1'b1;
      end
      OP_CONNECT: if (s == ST_IDLE) begin
        pr_role   = ROLE_CONTROLLER;
        pr_state  = ST_CONNECTING;
        pr_resume = 1'b0;
        pr_gen    = pr_gen + 1'b1;
        ok        = 1'b1;
      end
      OP_AWAIT: begin
        // only the listening side opens a new generation here
        if (s == ST_LISTENING) begin
          pr_gen   = pr_gen + 1'b1;
          pr_state = ST_AWAITING;
          ok       = 1'b1;
        end else if (s == ST_CONNECTING) begin
          pr_state = ST_AWAITING;
          ok       = 1'b1;
        end
      end
      OP_APPROVE: if (s == ST_AWAITING) begin
        pr_state = ST_NEGOTIATING;
        ok       = 1'b1;
      end
      OP_REJECT: if (s == ST_AWAITING) begin
        pr_state  = (pr_role == ROLE_CONTROLLED) ? ST_LISTENING : ST_IDLE;
        pr_resume = 1'b0;
        ok        = 1'b1;
      end
      OP_CONNECTED: if (s == ST_NEGOTIATING || s == ST_CONNECTED) begin
        pr_state  = ST_CONNECTED;
        pr_resume = 1'b0;
        ok        = 1'b1;
      end
      OP_STREAM: if (s == ST_CONNECTED) begin
        pr_state  = ST_STREAMING;
        pr_resume = 1'b0;
        ok        = 1'b1;
      end
      OP_UNSTREAM: if (s == ST_STREAMING) begin
        pr_state  = ST_CONNECTED;
        pr_resume = 1'b0;
        ok        = 1'b1;
      end
      OP_RECONNECT: if (live_state(s) && s != ST_RECONNECTING) begin
        pr_resume = (s == ST_STREAMING);
        pr_state  = ST_RECONNECTING;
        ok        = 1'b1;
      end
      OP_RESTORE: if (s == ST_RECONNECTING) begin
        pr_state  = pr_resume ? ST_STREAMING : ST_CONNECTED;
        pr_resume = 1'b0;
        ok        = 1'b1;
      end
      OP_STOP: if (!(s inside {ST_IDLE, ST_STOPPING, ST_TIMEDOUT})) begin
        pr_state = ST_STOPPING;
        ok       = 1'b1;
      end
      OP_TIMEOUT: if (s == ST_STOPPING) begin
        pr_state = ST_TIMEDOUT;
        ok       = 1'b1;
      end
      OP_FINISH: begin
        // always taken; role and generation stay
        pr_state  = (keep && pr_role == ROLE_CONTROLLED) ? ST_LISTENING : ST_IDLE;
        pr_resume = 1'b0;
        ok        = 1'b1;
      end
      OP_QUERY: ok = 1'b1;
      default: ;   // unused code: refused, no change
    endcase

    s            = pr_state;
    v.accepted   = ok;
    v.state      = s;
    v.role       = pr_role;
    v.gen        = pr_gen;
    v.desk       = (pr_role == ROLE_CONTROLLER) && (s == ST_CONNECTED);
    v.ctl_stream = (pr_role == ROLE_CONTROLLED) && (s == ST_CONNECTED);
    v.send_in    = (pr_role == ROLE_CONTROLLER) && (s == ST_STREAMING);
    v.recv_in    = (pr_role == ROLE_CONTROLLED) && (s == ST_STREAMING);
    v.clip       = (s == ST_STREAMING);
    v.negot      = s inside {ST_CONNECTING, ST_AWAITING, ST_NEGOTIATING};
    v.active     = live_state(s);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Random events: three in four are legal for the mirrored state, so the
  // walk reaches streaming, reconnect and teardown often; the rest is any
  // code at all, the unused one included.
  // --------------------------------------------------------------------------
  function automatic steer_row_t roll_event();
    steer_row_t r;
    op_t        opts[$];
    r          = '0;
    r.new_role = 1'($urandom_range(1));
    r.keep     = 1'($urandom_range(1));
    if ($urandom_range(99) < 25) begin
      r.op = OpW'($urandom_range(15));
      return r;
    end
    case (pr_state)
      ST_IDLE:         opts = '{OP_LISTEN, OP_CONNECT, OP_SET_ROLE};
      ST_LISTENING:    opts = '{OP_AWAIT, OP_AWAIT, OP_STOP, OP_FINISH};
      ST_CONNECTING:   opts = '{OP_AWAIT, OP_AWAIT, OP_STOP, OP_FINISH};
      ST_AWAITING:     opts = '{OP_APPROVE, OP_APPROVE, OP_REJECT, OP_STOP};
      ST_NEGOTIATING:  opts = '{OP_CONNECTED, OP_CONNECTED, OP_RECONNECT, OP_STOP};
      ST_CONNECTED:    opts = '{OP_STREAM, OP_STREAM, OP_CONNECTED, OP_RECONNECT,
                                OP_STOP, OP_QUERY};
      ST_STREAMING:    opts = '{OP_UNSTREAM, OP_RECONNECT, OP_RECONNECT, OP_STOP,
                                OP_QUERY};
      ST_RECONNECTING: opts = '{OP_RESTORE, OP_RESTORE, OP_STOP};
      ST_STOPPING:     opts = '{OP_TIMEOUT, OP_FINISH};
      default:         opts = '{OP_FINISH};
    endcase
    r.op = opts[$urandom_range(opts.size() - 1)];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Source side. Called just after a rising edge; returns at the edge where
  // the transfer happened, with valid still high so the next call may keep
  // it up without a glitch.
  // --------------------------------------------------------------------------
  task automatic offer(steer_row_t r);
    sess_view_t v;
    if (!calm) begin
      while ($urandom_range(99) < 9) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid          <= 1'b1;
    in_if.operation      <= r.op;
    in_if.new_role       <= r.new_role;
    in_if.keep_listening <= r.keep;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    // transfer taken at this edge: predict now so the next roll sees it
    v = advance_session(r.op, r.new_role, r.keep);
    if (r.pinned) begin
      v.accepted = r.acc;
      v.state    = r.st;
      v.gen      = r.gen;
    end
    pending_views.push_back(v);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [GenW-1:0] got,
                                 logic [GenW-1:0] want);
    $display("%0t: result %0d %s: got %0h want %0h", $realtime, n_seen, what,
             got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [GenW-1:0] got,
                             logic [GenW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    sess_view_t want;
    if (pending_views.size() == 0) begin
      report_mismatch("result with nothing pending",
                      GenW'(out_if.session_state), '0);
      return;
    end
    want = pending_views.pop_front();
    check_field("accepted", GenW'(out_if.accepted), GenW'(want.accepted));
    check_field("session_state", GenW'(out_if.session_state), GenW'(want.state));
    check_field("current_role", GenW'(out_if.current_role), GenW'(want.role));
    check_field("session_generation", out_if.session_generation, want.gen);
    check_field("can_enter_remote_desktop",
                GenW'(out_if.can_enter_remote_desktop), GenW'(want.desk));
    check_field("can_start_controlled_streaming",
                GenW'(out_if.can_start_controlled_streaming),
                GenW'(want.ctl_stream));
    check_field("can_send_input", GenW'(out_if.can_send_input),
                GenW'(want.send_in));
    check_field("can_receive_input", GenW'(out_if.can_receive_input),
                GenW'(want.recv_in));
    check_field("can_sync_clipboard", GenW'(out_if.can_sync_clipboard),
                GenW'(want.clip));
    check_field("in_negotiation", GenW'(out_if.in_negotiation),
                GenW'(want.negot));
    check_field("has_active_session", GenW'(out_if.has_active_session),
                GenW'(want.active));
    n_seen++;
  endtask

  // Values seen here are the ones the block sampled at this edge
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result();
  end

  // --------------------------------------------------------------------------
  // Sink side: random stalls, none while calm, and one long hold-off on
  // request, counted here so the source keeps pushing into a full pipe.
  // --------------------------------------------------------------------------
  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.operation      <= OP_QUERY;
    in_if.new_role       <= 1'b0;
    in_if.keep_listening <= 1'b0;

    pr_state  = ST_IDLE;
    pr_role   = ROLE_CONTROLLER;
    pr_resume = 1'b0;
    pr_gen    = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steer_tbl[i]) offer(steer_tbl[i]);

    // random phase: idling, then a calm stretch, then idling with one
    // long sink hold-off partway through
    for (int k = 0; k < RandEvents; k++) begin
      calm = (k >= 150 && k < 300);
      if (k == 400) hold_req = 1'b1;
      offer(roll_event());
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    // drain, then keep waiting briefly to catch stray results
    for (int w = 0; w < DrainLimit && pending_views.size() != 0; w++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_views.size() != 0)
      report_mismatch("results never delivered", GenW'(pending_views.size()), '0);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #200_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: session_lifecycle_fsm_top.f
rtl/slf_pkg.sv
rtl/slf_if.sv
rtl/slf_guard.sv
rtl/session_lifecycle_fsm_top.sv
test/session_lifecycle_fsm_top_tb.sv
